@@ rtl/gcdo_pkg.sv @@
package gcdo_pkg;

  // Micro-program counter width and step addresses.
  typedef logic [2:0] upc_t;

  localparam upc_t UPC_IDLE   = 3'd0;
  localparam upc_t UPC_CHECK  = 3'd1;
  localparam upc_t UPC_COMMON = 3'd2;
  localparam upc_t UPC_SHR_A  = 3'd3;
  localparam upc_t UPC_SHR_B  = 3'd4;
  localparam upc_t UPC_SUB    = 3'd5;
  localparam upc_t UPC_EMIT   = 3'd6;

  // Datapath operations selected by a control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SHR_BOTH,
    OP_SHR_A,
    OP_SHR_B,
    OP_SUB,
    OP_EMIT
  } op_t;

  // Branch conditions tested by the sequencer.
  typedef enum logic [2:0] {
    C_IN_VALID,
    C_ANY_ZERO,
    C_BOTH_EVEN,
    C_A_EVEN,
    C_B_EVEN,
    C_A_EQ_B,
    C_OUT_BUSY
  } cond_t;

  // One micro-instruction: operation, condition and both successors.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  tgt_true;
    upc_t  tgt_false;
  } ucw_t;

  // Status flags reported by the datapath to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic any_zero;
    logic both_even;
    logic a_even;
    logic b_even;
    logic a_eq_b;
    logic out_busy;
  } dp_flags_t;

endpackage

@@ rtl/gcdo_rom.sv @@
module gcdo_rom
  import gcdo_pkg::*;
(
  input  upc_t upc,
  output ucw_t ucw
);

  // Binary GCD microprogram. Unless an operand is zero, common factors of two
  // are counted first, then both values are made odd and reduced by subtraction.
  always_comb begin
    unique case (upc)
      UPC_IDLE:   ucw = '{op: OP_LOAD,     cond: C_IN_VALID,
                          tgt_true: UPC_CHECK,  tgt_false: UPC_IDLE};
      UPC_CHECK:  ucw = '{op: OP_NOP,      cond: C_ANY_ZERO,
                          tgt_true: UPC_EMIT,   tgt_false: UPC_COMMON};
      UPC_COMMON: ucw = '{op: OP_SHR_BOTH, cond: C_BOTH_EVEN,
                          tgt_true: UPC_COMMON, tgt_false: UPC_SHR_A};
      UPC_SHR_A:  ucw = '{op: OP_SHR_A,    cond: C_A_EVEN,
                          tgt_true: UPC_SHR_A,  tgt_false: UPC_SHR_B};
      UPC_SHR_B:  ucw = '{op: OP_SHR_B,    cond: C_B_EVEN,
                          tgt_true: UPC_SHR_B,  tgt_false: UPC_SUB};
      UPC_SUB:    ucw = '{op: OP_SUB,      cond: C_A_EQ_B,
                          tgt_true: UPC_EMIT,   tgt_false: UPC_SHR_B};
      UPC_EMIT:   ucw = '{op: OP_EMIT,     cond: C_OUT_BUSY,
                          tgt_true: UPC_EMIT,   tgt_false: UPC_IDLE};
      default:    ucw = '{op: OP_NOP,      cond: C_IN_VALID,
                          tgt_true: UPC_IDLE,   tgt_false: UPC_IDLE};
    endcase
  end

endmodule

@@ rtl/gcdo_seq.sv @@
module gcdo_seq
  import gcdo_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ucw_t      ucw,
  input  dp_flags_t flags,
  output upc_t      upc,
  output logic      idle
);

  upc_t upc_r;
  upc_t upc_nxt;
  logic taken;

  // Select the condition named by the current control word.
  always_comb begin
    unique case (ucw.cond)
      C_IN_VALID:  taken = flags.in_valid;
      C_ANY_ZERO:  taken = flags.any_zero;
      C_BOTH_EVEN: taken = flags.both_even;
      C_A_EVEN:    taken = flags.a_even;
      C_B_EVEN:    taken = flags.b_even;
      C_A_EQ_B:    taken = flags.a_eq_b;
      C_OUT_BUSY:  taken = flags.out_busy;
      default:     taken = 1'b0;
    endcase
  end

  // Two-way branch on every step.
  always_comb begin
    upc_nxt = taken ? ucw.tgt_true : ucw.tgt_false;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign upc  = upc_r;
  assign idle = (upc_r == UPC_IDLE);

endmodule

@@ rtl/gcdo_dp.sv @@
module gcdo_dp
  import gcdo_pkg::*;
#(
  parameter int OPERAND_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  op_t                     op,
  input  logic                    in_valid,
  input  logic [OPERAND_BITS-1:0] operand_a,
  input  logic [OPERAND_BITS-1:0] operand_b,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [OPERAND_BITS-1:0] divisor,
  output logic                    zero_operand,
  output dp_flags_t               flags
);

  localparam int KW = $clog2(OPERAND_BITS);

  logic [OPERAND_BITS-1:0] a_r, a_nxt;
  logic [OPERAND_BITS-1:0] b_r, b_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic                    zf_r, zf_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OPERAND_BITS-1:0] out_div_r, out_div_nxt;
  logic                    out_zero_r, out_zero_nxt;
  logic [OPERAND_BITS:0]   diff;
  logic                    out_busy;
  logic                    both_even;

  assign diff      = {1'b0, a_r} - {1'b0, b_r};
  assign out_busy  = out_valid_r && !out_ready;
  assign both_even = !a_r[0] && !b_r[0];

  // Working registers: one operation per micro-step.
  always_comb begin
    a_nxt  = a_r;
    b_nxt  = b_r;
    k_nxt  = k_r;
    zf_nxt = zf_r;
    case (op)
      OP_LOAD: begin
        a_nxt  = operand_a;
        b_nxt  = operand_b;
        k_nxt  = '0;
        zf_nxt = (operand_a == '0) || (operand_b == '0);
      end
      OP_SHR_BOTH: begin
        if (both_even) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end
      end
      OP_SHR_A: begin
        if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end
      end
      OP_SHR_B: begin
        if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end
      end
      OP_SUB: begin
        // Keep the smaller value in a and the difference in b.
        if (diff[OPERAND_BITS]) begin
          b_nxt = b_r - a_r;
        end else begin
          a_nxt = b_r;
          b_nxt = diff[OPERAND_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded on the emit step once the slot is free.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_div_nxt   = out_div_r;
    out_zero_nxt  = out_zero_r;
    if (op == OP_EMIT && !out_busy) begin
      out_valid_nxt = 1'b1;
      out_div_nxt   = zf_r ? '0 : (a_r << k_r);
      out_zero_nxt  = zf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    k_r        <= k_nxt;
    zf_r       <= zf_nxt;
    out_div_r  <= out_div_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign out_valid    = out_valid_r;
  assign divisor      = out_div_r;
  assign zero_operand = out_zero_r;

  assign flags = '{in_valid:  in_valid,
                   any_zero:  zf_r,
                   both_even: both_even,
                   a_even:    !a_r[0],
                   b_even:    !b_r[0],
                   a_eq_b:    (a_r == b_r),
                   out_busy:  out_busy};

  // A flagged result always carries a zero divisor.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |-> out_div_r == '0)
    else $error("flagged result with nonzero divisor");

  // Subtraction only ever sees two odd values.
  a_sub_odd: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_SUB |-> a_r[0] && b_r[0])
    else $error("subtract step with an even operand");

  // At the emit step of a normal item the odd part sits in a and b is spent.
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_EMIT && !zf_r |-> a_r[0] && b_r == '0)
    else $error("emit step reached before reduction finished");

  // The count of shared factors of two never reaches the operand width.
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_SHR_BOTH |-> 32'(k_r) < OPERAND_BITS)
    else $error("common shift count out of range");

endmodule

@@ rtl/gcd_two_operands.sv @@
// Greatest common divisor of two unsigned OPERAND_BITS-wide operands, one
// result per input transaction. A small microprogram steps a single binary
// GCD datapath one micro-instruction per clock: common factors of two are
// shifted out and counted, the remaining values are made odd and reduced by
// subtract-and-shift until they match, and the match shifted back up is the
// divisor. An item occupies the sequencer for one micro-step to accept, one
// to check for a zero operand, one per shift plus one to leave each shift
// loop, two per subtract round and one to emit. If either operand is zero
// the result is a zero divisor with zero_operand set. The emit step waits
// while the previous result is still unread. A new operand pair is taken
// while the previous result still waits in the output register.
module gcd_two_operands
  import gcdo_pkg::*;
#(
  parameter int OPERAND_BITS = 31
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: operand_a, operand_b, zero fill.
  input  logic [((2*OPERAND_BITS+7)/8)*8-1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: divisor, zero fill.
  output logic [((OPERAND_BITS+7)/8)*8-1:0]   out_tdata,
  // Fields from bit 0: zero_operand.
  output logic                              out_tuser
);

  localparam int OUT_W = ((OPERAND_BITS + 7) / 8) * 8;

  upc_t                    upc;
  ucw_t                    ucw;
  dp_flags_t               flags;
  logic                    idle;
  logic [OPERAND_BITS-1:0] divisor;

  gcdo_rom u_rom (
    .upc (upc),
    .ucw (ucw)
  );

  gcdo_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .ucw   (ucw),
    .flags (flags),
    .upc   (upc),
    .idle  (idle)
  );

  gcdo_dp #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (ucw.op),
    .in_valid     (in_tvalid),
    .operand_a    (in_tdata[OPERAND_BITS-1:0]),
    .operand_b    (in_tdata[2*OPERAND_BITS-1:OPERAND_BITS]),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .divisor      (divisor),
    .zero_operand (out_tuser),
    .flags        (flags)
  );

  // Operands are taken only at the idle step of the microprogram.
  assign in_tready = idle;
  assign out_tdata = OUT_W'(divisor);

endmodule

@@ dv/gcd_two_operands_tb.sv @@
`timescale 1ns / 1ps

module gcd_two_operands_tb;

  localparam int OPERAND_BITS = 31;
  localparam int IN_W         = ((2*OPERAND_BITS+7)/8)*8;
  localparam int OUT_W        = ((OPERAND_BITS+7)/8)*8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_CYCLES = 2*OPERAND_BITS + 16;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef logic [OPERAND_BITS-1:0] operand_t;

  // One expected result: the divisor and the zero operand flag.
  typedef struct {
    operand_t divisor;
    logic     zero_operand;
  } gcd_result_t;

  localparam operand_t OPERAND_MAX = '1;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  gcd_result_t expected_gcds[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;

  gcd_two_operands #(
    .OPERAND_BITS(OPERAND_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // Expected result of one operand pair, by Euclid's remainder iteration.
  function automatic gcd_result_t euclid_gcd(operand_t a, operand_t b);
    operand_t    x;
    operand_t    y;
    operand_t    r;
    gcd_result_t res;
    if (a == '0 || b == '0) begin
      res.divisor      = '0;
      res.zero_operand = 1'b1;
    end else begin
      x = a;
      y = b;
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.divisor      = x;
      res.zero_operand = 1'b0;
    end
    return res;
  endfunction

  function automatic operand_t random_operand(int width);
    operand_t v;
    v = operand_t'({$urandom, $urandom});
    if (width < OPERAND_BITS) begin
      v = v & ((operand_t'(1) << width) - operand_t'(1));
    end
    return v;
  endfunction

  // Offers one operand pair and waits for the input transaction. The valid
  // stays high on return so that a following pair can go out back to back.
  task automatic send_pair(operand_t a, operand_t b);
    logic [IN_W-1:0] data;
    data = '0;
    data[OPERAND_BITS-1:0] = a;
    data[2*OPERAND_BITS-1:OPERAND_BITS] = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    expected_gcds.push_back(euclid_gcd(a, b));
  endtask

  // Drops the valid and waits until every expected result has arrived.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_gcds.size() != 0) @(posedge clk);
  endtask

  task automatic test_zero_operands();
    send_pair('0, '0);
    send_pair('0, operand_t'(5));
    send_pair(operand_t'(7), '0);
    send_pair('0, OPERAND_MAX);
    send_pair(OPERAND_MAX, '0);
    drain_results();
  endtask

  task automatic test_extremes();
    send_pair(OPERAND_MAX, OPERAND_MAX);
    send_pair(operand_t'(1), OPERAND_MAX);
    send_pair(OPERAND_MAX, operand_t'(1));
    send_pair(operand_t'(1), operand_t'(1));
    send_pair(OPERAND_MAX, OPERAND_MAX - operand_t'(1));
    send_pair(OPERAND_MAX - operand_t'(1), OPERAND_MAX >> 1);
    drain_results();
  endtask

  // Equal operands, pure powers of two, multiples of a shared factor and
  // consecutive Fibonacci numbers, the slowest case for a remainder iteration.
  task automatic test_special_values();
    send_pair(operand_t'(12345), operand_t'(12345));
    send_pair(operand_t'(1) << 30, operand_t'(1) << 30);
    send_pair(operand_t'(1) << 30, operand_t'(3) << 29);
    send_pair(operand_t'(1) << 30, operand_t'(1));
    send_pair(operand_t'(2), operand_t'(1) << 30);
    send_pair(operand_t'(1134903170), operand_t'(1836311903));
    send_pair(operand_t'(1836311903), operand_t'(1134903170));
    send_pair(operand_t'(6) * operand_t'(1000003), operand_t'(10) * operand_t'(1000003));
    drain_results();
  endtask

  // Draws one operand pair from a mix of shapes: plain random, shared
  // factors, narrow values, multiples, powers of two and zero operands.
  task automatic random_pair(output operand_t a, output operand_t b);
    int       w;
    int       s;
    operand_t g;
    operand_t x;
    operand_t y;
    case ($urandom_range(9))
      0: begin
        a = ($urandom_range(1)) ? '0 : random_operand($urandom_range(1, OPERAND_BITS));
        b = (a != '0 && $urandom_range(1)) ? '0 : random_operand($urandom_range(1, OPERAND_BITS));
        if (a != '0 && b != '0) a = '0;
      end
      1, 2, 3: begin
        a = random_operand(OPERAND_BITS);
        b = random_operand(OPERAND_BITS);
      end
      4, 5, 6: begin
        // The product of a w-bit and a (31-w)-bit value cannot overflow.
        w = $urandom_range(1, 24);
        g = random_operand(w);
        x = random_operand(OPERAND_BITS - w);
        y = random_operand(OPERAND_BITS - w);
        if (g == '0) g = operand_t'(1);
        if (x == '0) x = operand_t'(1);
        if (y == '0) y = operand_t'(1);
        a = g * x;
        b = g * y;
      end
      7: begin
        a = random_operand($urandom_range(1, 8));
        b = random_operand($urandom_range(1, 8));
      end
      8: begin
        w = $urandom_range(1, OPERAND_BITS);
        s = $urandom_range(0, OPERAND_BITS - w);
        x = random_operand(w);
        if (x == '0) x = operand_t'(1);
        a = x << s;
        b = x;
        if ($urandom_range(1)) begin
          a = x;
          b = x << s;
        end
      end
      default: begin
        a = operand_t'(1) << $urandom_range(0, OPERAND_BITS - 1);
        b = random_operand(OPERAND_BITS - 8) << $urandom_range(0, 8);
      end
    endcase
  endtask

  task automatic test_random_phase(int count, int idle_pct, int stall_percent);
    operand_t a;
    operand_t b;
    send_idle_pct = idle_pct;
    stall_pct     = stall_percent;
    repeat (count) begin
      random_pair(a, b);
      send_pair(a, b);
    end
    drain_results();
  endtask

  // The receiver holds off while pairs keep coming, so the block fills up
  // and must stall its input until the receiver resumes.
  task automatic test_backpressure();
    operand_t a;
    operand_t b;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = HOLD_OFF_CYCLES;
    repeat (12) begin
      random_pair(a, b);
      send_pair(a, b);
    end
    drain_results();
  endtask

  // Receiver: random stalls, or a long hold-off counted here in cycles.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Compares each output transaction with the oldest expected result.
  always @(posedge clk) begin : check_results
    gcd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_gcds.size() == 0) begin
        note_mismatch("unexpected result", 0, out_tdata[OPERAND_BITS-1:0]);
      end else begin
        want = expected_gcds.pop_front();
        if (out_tdata[OPERAND_BITS-1:0] !== want.divisor) begin
          note_mismatch("divisor", want.divisor, out_tdata[OPERAND_BITS-1:0]);
        end
        if (out_tuser !== want.zero_operand) begin
          note_mismatch("zero_operand", want.zero_operand, out_tuser);
        end
      end
    end
  end

  // Run limit, far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_operands();
    test_extremes();
    test_special_values();
    test_random_phase(100, 0, 0);
    test_random_phase(100, 77, 0);
    test_backpressure();
    test_random_phase(100, 0, 77);
    test_random_phase(100, 34, 34);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_gcds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
